### src/adcs_pkg.sv
// Package: constants and types for the axis dead zone and curve scaler.
package adcs_pkg;

    localparam int AXIS_COUNT_MAX_DEF = 6;
    localparam int FRACTION_BITS_DEF  = 16;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 7;

    localparam logic [CFG_IDX_W-1:0] REG_DEAD_ZONE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SENSITIVITY = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_AXIS_COUNT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TRIGGERS    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ABS_MASK    = 3'd4;

    localparam int RANGE_MAX = 32767;

    // Fields of one result transfer.
    typedef struct packed {
        logic [17:0] position;
        logic [2:0]  axis_echo;
        logic        axis_present;
    } t_result;

endpackage

### src/adcs_divider.sv
// Pipelined restoring divider: one quotient bit per stage, stall-aware.
module adcs_divider
    import adcs_pkg::*;
#(
    parameter int NUM_W = 41,
    parameter int DEN_W = 17,
    parameter int TAG_W = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    input  logic [TAG_W-1:0] i_tag,
    output logic             o_valid,
    output logic [NUM_W-1:0] o_quot,
    output logic [TAG_W-1:0] o_tag
);
    localparam int REM_W = DEN_W + 1;

    // stage k holds its outputs at index k
    logic             r_vld [NUM_W];
    logic [NUM_W-1:0] r_num [NUM_W];
    logic [REM_W-1:0] r_rem [NUM_W];
    logic [DEN_W-1:0] r_den [NUM_W];
    logic [TAG_W-1:0] r_tag [NUM_W];

    for (genvar k = 0; k < NUM_W; k++) begin : g_stage
        logic             w_vld_in;
        logic [NUM_W-1:0] w_num_in;
        logic [REM_W-1:0] w_rem_in;
        logic [DEN_W-1:0] w_den_in;
        logic [TAG_W-1:0] w_tag_in;
        logic [REM_W-1:0] n_sh;
        logic [REM_W:0]   n_diff;

        if (k == 0) begin : g_first
            assign w_vld_in = i_valid;
            assign w_num_in = i_num;
            assign w_rem_in = '0;
            assign w_den_in = i_den;
            assign w_tag_in = i_tag;
        end else begin : g_next
            assign w_vld_in = r_vld[k-1];
            assign w_num_in = r_num[k-1];
            assign w_rem_in = r_rem[k-1];
            assign w_den_in = r_den[k-1];
            assign w_tag_in = r_tag[k-1];
        end

        always_comb begin
            n_sh   = {w_rem_in[REM_W-2:0], w_num_in[NUM_W-1]};
            n_diff = {1'b0, n_sh} - {2'b00, w_den_in};
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= w_vld_in;
            end
            if (i_en) begin
                r_den[k] <= w_den_in;
                r_tag[k] <= w_tag_in;
                if (!n_diff[REM_W]) begin
                    r_rem[k] <= n_diff[REM_W-1:0];
                    r_num[k] <= {w_num_in[NUM_W-2:0], 1'b1};
                end else begin
                    r_rem[k] <= n_sh;
                    r_num[k] <= {w_num_in[NUM_W-2:0], 1'b0};
                end
            end
        end
    end

    assign o_valid = r_vld[NUM_W-1];
    assign o_quot  = r_num[NUM_W-1];
    assign o_tag   = r_tag[NUM_W-1];
endmodule

### src/axis_deadzone_curve_scaler.sv
// Top level: axis dead zone and response curve scaler, pipelined.
// Throughput: one transfer per cycle; the long-division pipeline sets the depth.
// A stall holds the whole pipeline; a two-entry skid buffer parts the output.
// Reset (synchronous, active low) clears readings, centres, valid bits and
// restores the register defaults.
module axis_deadzone_curve_scaler
    import adcs_pkg::*;
#(
    parameter int AXIS_COUNT_MAX = AXIS_COUNT_MAX_DEF,
    parameter int FRACTION_BITS  = FRACTION_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // axis_number[2:0], sample_value[18:3], zero fill [23:19]
    input  logic [23:0]           s_axis_tdata,
    // recenter
    input  logic                  s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // position[17:0], axis_echo[20:18], axis_present[21], zero fill [23:22]
    output logic [23:0]           m_axis_tdata
);
    localparam int AW    = (AXIS_COUNT_MAX > 1) ? $clog2(AXIS_COUNT_MAX) : 1;
    localparam int FB    = FRACTION_BITS;
    localparam int PW    = FB + 1;          // p in 0..F1
    localparam int NUM_W = 17 + FB;          // d*F1, d <= 65535
    localparam int DEN_W = 17;
    localparam int TAG_W = 1 + 1 + 3 + 1 + 4;

    // ---------------- configuration
    logic [6:0] r_dzp;
    logic [3:0] r_sens;
    logic [2:0] r_cnt;
    logic       r_trig;
    logic [5:0] r_abs;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dzp <= 7'd10; r_sens <= 4'd9; r_cnt <= '0; r_trig <= 1'b0; r_abs <= 6'd4;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_DEAD_ZONE:   r_dzp  <= i_cfg_data[6:0];
                REG_SENSITIVITY: r_sens <= i_cfg_data[3:0];
                REG_AXIS_COUNT:  r_cnt  <= i_cfg_data[2:0];
                REG_TRIGGERS:    r_trig <= i_cfg_data[0];
                REG_ABS_MASK:    r_abs  <= i_cfg_data[5:0];
                default: ;
            endcase
        end
    end

    logic [4:0] n_live;
    always_comb begin
        if (32'(r_cnt) > AXIS_COUNT_MAX) n_live = 5'(AXIS_COUNT_MAX);
        else                             n_live = 5'(r_cnt);
    end

    // ---------------- pipeline enable
    logic w_en;
    logic       in_xfer;
    assign in_xfer = s_axis_tvalid && s_axis_tready;

    // ---------------- stage 1: store readings, latch centres
    logic [2:0]  in_axis;
    logic [15:0] in_val;
    assign in_axis = s_axis_tdata[2:0];
    assign in_val  = s_axis_tdata[18:3];

    logic signed [15:0] r_cur [AXIS_COUNT_MAX];
    logic signed [15:0] r_cen [AXIS_COUNT_MAX];
    logic signed [15:0] n_cur [AXIS_COUNT_MAX];

    always_comb begin
        for (int i = 0; i < AXIS_COUNT_MAX; i++) begin
            n_cur[i] = r_cur[i];
            if (32'(in_axis) == i) n_cur[i] = in_val;
        end
    end

    logic               r1_v, r1_pres, r1_abs, r1_lo0;
    logic [2:0]         r1_axis;
    logic signed [15:0] r1_cur, r1_cen;
    logic [6:0]         r1_dzp;
    logic [3:0]         r1_s;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            for (int i = 0; i < AXIS_COUNT_MAX; i++) begin
                r_cur[i] <= '0; r_cen[i] <= '0;
            end
        end else if (w_en) begin
            r1_v <= in_xfer;
            if (in_xfer) begin
                for (int i = 0; i < AXIS_COUNT_MAX; i++) begin
                    r_cur[i] <= n_cur[i];
                    if (s_axis_tuser)
                        r_cen[i] <= (5'(i) < n_live) ? n_cur[i] : 16'sd0;
                end
            end
        end
        if (w_en) begin
            r1_axis <= in_axis;
            r1_pres <= (5'(in_axis) < n_live);
            r1_abs  <= (in_axis < 3'd6) && r_abs[in_axis];
            r1_lo0  <= r_trig && (32'(in_axis) + 2 >= AXIS_COUNT_MAX);
            r1_cur  <= in_val;
            r1_cen  <= (s_axis_tuser && 5'(in_axis) < n_live) ? $signed(in_val)
                     : ((s_axis_tuser) ? 16'sd0 : r_cen[in_axis[AW-1:0]]);
            r1_dzp  <= r_dzp;
            r1_s    <= (r_sens > 4'd9) ? 4'd9 : r_sens;
        end
    end

    // ---------------- stage 2: offsets and dead-zone product
    logic signed [17:0] r2_off, r2_lo, r2_cen;
    logic [22:0]        r2_dzm;           // span * pct
    logic [15:0]        r2_span;
    logic               r2_v, r2_pres, r2_abs;
    logic [2:0]         r2_axis;
    logic [3:0]         r2_s;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r2_v <= 1'b0;
        else if (w_en) r2_v <= r1_v;
        if (w_en) begin
            r2_lo   <= r1_lo0 ? 18'sd0 : -18'sd32768;
            r2_off  <= 18'(r1_cur) - 18'(r1_cen);
            r2_cen  <= 18'(r1_cen);
            r2_span <= r1_lo0 ? 16'd32767 : 16'd65535;
            r2_dzm  <= (r1_lo0 ? 23'd32767 : 23'd65535) * 23'(r1_dzp);
            r2_pres <= r1_pres; r2_abs <= r1_abs; r2_axis <= r1_axis; r2_s <= r1_s;
        end
    end

    // ---------------- stage 3: dead zone = span*pct/100 via reciprocal
    // 2^30/100 rounded up is exact for this operand range.
    logic [22:0] r3_dz;
    logic signed [17:0] r3_off, r3_lo, r3_cen, r3_cur;
    logic [15:0] r3_span;
    logic r3_v, r3_pres, r3_abs; logic [2:0] r3_axis; logic [3:0] r3_s;
    logic [46:0] w_dzq;
    assign w_dzq = 47'(r2_dzm) * 47'd10737419;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r3_v <= 1'b0;
        else if (w_en) r3_v <= r2_v;
        if (w_en) begin
            r3_dz  <= 23'(w_dzq >> 30);
            r3_off <= r2_off; r3_lo <= r2_lo; r3_cen <= r2_cen;
            r3_cur <= r2_off + r2_cen;
            r3_span <= r2_span;
            r3_pres <= r2_pres; r3_abs <= r2_abs; r3_axis <= r2_axis; r3_s <= r2_s;
        end
    end

    // ---------------- stage 4: numerator/denominator select
    logic signed [19:0] w_ndz, w_rng, w_d, w_v;
    logic w_zero, w_full, w_neg;
    always_comb begin
        w_ndz  = 20'(r3_dz);
        w_neg  = r3_off < 0;
        w_zero = 1'b0; w_full = 1'b0;
        w_rng  = '0; w_d = '0;
        if (r3_abs) begin
            w_v = 20'(r3_cur) - 20'(r3_lo);
            w_rng = 20'(r3_span);
            w_d = (w_v < 0) ? 20'sd0 : ((w_v > w_rng) ? w_rng : w_v);
            w_neg = 1'b0;
        end else begin
            w_v = '0;
            if (20'(r3_off) < -w_ndz) begin
                w_rng = 20'(r3_cen) - 20'(r3_lo) - w_ndz;
                w_d   = -20'(r3_off) - w_ndz;
            end else if (20'(r3_off) > w_ndz) begin
                w_rng = 20'sd32767 - 20'(r3_cen) - w_ndz;
                w_d   = 20'(r3_off) - w_ndz;
            end else begin
                w_zero = 1'b1;
            end
            if (!w_zero && w_rng <= 0) w_full = 1'b1;
            else if (w_d > w_rng) w_d = w_rng;
        end
        if (!r3_pres) w_zero = 1'b1;
    end

    logic               r4_v;
    logic [NUM_W-1:0]   r4_num;
    logic [DEN_W-1:0]   r4_den;
    logic [TAG_W-1:0]   r4_tag;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r4_v <= 1'b0;
        else if (w_en) r4_v <= r3_v;
        if (w_en) begin
            r4_num <= NUM_W'(w_full ? 20'sd1 : w_d) << FB;
            r4_den <= w_full ? 17'd1 : DEN_W'(w_rng);
            // tag: zero, neg, axis, pres, sens(abs => 9)
            r4_tag <= {w_zero, w_neg, r3_axis, r3_pres, (r3_abs ? 4'd9 : r3_s)};
        end
    end

    logic             d_v;
    logic [NUM_W-1:0] d_q;
    logic [TAG_W-1:0] d_tag;
    adcs_divider #(.NUM_W(NUM_W), .DEN_W(DEN_W), .TAG_W(TAG_W)) u_div (
        .i_clk, .i_rst_n, .i_en(w_en), .i_valid(r4_v), .i_num(r4_num), .i_den(r4_den),
        .i_tag(r4_tag), .o_valid(d_v), .o_quot(d_q), .o_tag(d_tag)
    );

    // ---------------- curve: p2, p4, p5, blend
    logic r5_v, r6_v, r7_v, r8_v, r9_v;
    logic [PW-1:0] r5_p, r6_p, r7_p, r8_p, r6_p2, r7_p4, r8_p5;
    logic [TAG_W-1:0] r5_t, r6_t, r7_t, r8_t, r9_t;
    logic [PW+3:0] r9_sum;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_v <= 1'b0; r6_v <= 1'b0; r7_v <= 1'b0; r8_v <= 1'b0; r9_v <= 1'b0;
        end else if (w_en) begin
            r5_v <= d_v; r6_v <= r5_v; r7_v <= r6_v; r8_v <= r7_v; r9_v <= r8_v;
        end
        if (w_en) begin
            r5_p  <= PW'(d_q);  r5_t <= d_tag;
            r6_p2 <= PW'((2*PW)'(r5_p) * (2*PW)'(r5_p) >> FB);
            r6_p  <= r5_p; r6_t <= r5_t;
            r7_p4 <= PW'((2*PW)'(r6_p2) * (2*PW)'(r6_p2) >> FB);
            r7_p  <= r6_p; r7_t <= r6_t;
            r8_p5 <= PW'((2*PW)'(r7_p4) * (2*PW)'(r7_p) >> FB);
            r8_p  <= r7_p; r8_t <= r7_t;
            r9_sum <= (PW+4)'(r8_p) * (PW+4)'(r8_t[3:0])
                    + (PW+4)'(r8_p5) * (PW+4)'(4'd9 - r8_t[3:0]);
            r9_t <= r8_t;
        end
    end

    // /9 by reciprocal with one correction step
    localparam int RW = PW + 4;
    logic r10_v; logic [TAG_W-1:0] r10_t;
    logic [RW-1:0] r10_q, r10_x;
    logic [2*RW+4:0] w_recip;
    localparam logic [RW+1:0] RECIP9 = (RW+2)'(((64'd1 << (RW+3)) / 9));
    assign w_recip = (2*RW+5)'(r9_sum) * (2*RW+5)'(RECIP9);
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r10_v <= 1'b0;
        else if (w_en) r10_v <= r9_v;
        if (w_en) begin
            r10_q <= RW'(w_recip >> (RW+3));
            r10_x <= r9_sum;
            r10_t <= r9_t;
        end
    end

    logic [RW-1:0] w_q, w_rem;
    logic signed [RW:0] w_pos;
    t_result w_res;
    always_comb begin
        w_rem = r10_x - RW'(r10_q * RW'(9));
        w_q   = (w_rem >= RW'(9)) ? r10_q + RW'(1) : r10_q;
        w_pos = r10_t[8] ? -$signed({1'b0, w_q}) : $signed({1'b0, w_q});
        if (r10_t[9]) w_pos = '0;
        w_res.position     = 18'(w_pos);
        w_res.axis_echo    = r10_t[7:5];
        w_res.axis_present = r10_t[4];
    end

    // ---------------- output skid: two entries keep the stream flowing
    t_result r_q0, r_q1;
    logic    r_q0v, r_q1v;
    logic    w_pop, w_push;
    assign w_en = !r_q1v;
    assign s_axis_tready = w_en;
    assign w_pop  = r_q0v && m_axis_tready;
    assign w_push = w_en && r10_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q0v <= 1'b0; r_q1v <= 1'b0;
        end else begin
            priority if (w_pop) begin
                if (r_q1v) begin
                    r_q0 <= r_q1; r_q1v <= w_push;
                    if (w_push) r_q1 <= w_res;
                end else begin
                    r_q0v <= w_push;
                    if (w_push) r_q0 <= w_res;
                end
            end else if (w_push) begin
                if (r_q0v) begin r_q1 <= w_res; r_q1v <= 1'b1; end
                else       begin r_q0 <= w_res; r_q0v <= 1'b1; end
            end
        end
    end

    assign m_axis_tvalid = r_q0v;
    assign m_axis_tdata  = {2'b00, r_q0.axis_present, r_q0.axis_echo, r_q0.position};
endmodule

### src/adcs_checker.sv
// Checker on the scaler's ports, bound to the top level.
module adcs_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata
);
    a_valid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("output valid dropped under stall");
    a_data_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("output data changed under stall");
    a_absent_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tdata[21] |-> m_axis_tdata[17:0] == 18'd0)
        else $error("absent axis with non-zero position");
    a_fill_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[23:22] == 2'b00)
        else $error("padding bits set");
endmodule

bind axis_deadzone_curve_scaler adcs_checker u_adcs_checker (
    .i_clk, .i_rst_n, .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
);

### tb/tb.sv
// Testbench for the axis dead zone and response curve scaler.
`timescale 1ns / 1ps

class axis_scoreboard;
    logic [21:0] pos_q[$];   // {present, echo, position}
    logic [6:0]  dz_pct;
    logic [3:0]  sens;
    logic [2:0]  n_axes;
    logic        trig;
    logic [5:0]  abs_mask;
    int          cur[6];
    int          cen[6];
    int          errors;

    function new();
        dz_pct = 10; sens = 9; n_axes = 0; trig = 0; abs_mask = 6'd4;
        errors = 0;
        for (int i = 0; i < 6; i++) begin
            cur[i] = 0; cen[i] = 0;
        end
    endfunction

    function longint low_end(int a);
        if (trig && a + 2 >= 6) return 0;
        return -32768;
    endfunction

    function longint shaped(int a);
        longint lo, off, dz, rng, d, p, p2, p4, p5, s, y;
        lo = low_end(a);
        off = cur[a] - cen[a];
        dz = ((32767 - lo) * dz_pct) / 100;
        if (off < -dz) begin
            rng = cen[a] - lo - dz; d = -off - dz;
        end else if (off > dz) begin
            rng = 32767 - cen[a] - dz; d = off - dz;
        end else begin
            return 0;
        end
        if (rng <= 0) p = 65536;
        else begin
            if (d > rng) d = rng;
            p = (d * 65536) / rng;
        end
        p2 = (p * p) >>> 16;
        p4 = (p2 * p2) >>> 16;
        p5 = (p4 * p) >>> 16;
        s = sens > 9 ? 9 : sens;
        y = (p * s + p5 * (9 - s)) / 9;
        return off < 0 ? -y : y;
    endfunction

    function void note_sample(logic [2:0] a, logic signed [15:0] v, logic rc);
        int n;
        longint pos, lo, rng, x;
        logic pres;
        n = n_axes > 6 ? 6 : n_axes;
        pres = a < n;
        pos = 0;
        if (a < 6) cur[a] = v;
        if (rc) for (int i = 0; i < 6; i++) cen[i] = i < n ? cur[i] : 0;
        if (pres) begin
            if (abs_mask[a]) begin
                lo = low_end(a);
                rng = 32767 - lo;
                x = cur[a] - lo;
                if (x < 0) x = 0;
                if (x > rng) x = rng;
                pos = (x * 65536) / rng;
            end else begin
                pos = shaped(a);
            end
        end
        pos_q.push_back({pres, a, pos[17:0]});
    endfunction

    function void check_result(logic [23:0] got);
        logic [21:0] exp;
        if (pos_q.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected result %h", got);
            return;
        end
        exp = pos_q.pop_front();
        if (got[21:0] !== exp || got[23:22] !== 2'b00) begin
            errors++;
            if (errors <= 10)
                $display("mismatch: exp pos %h echo %0d pres %b, got pos %h echo %0d pres %b",
                         exp[17:0], exp[20:18], exp[21], got[17:0], got[20:18], got[21]);
        end
    endfunction
endclass

module tb;
    import adcs_pkg::*;

    logic        i_clk, i_rst_n;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_index;
    logic [6:0]  i_cfg_data;
    logic        s_axis_tvalid, s_axis_tready, s_axis_tuser;
    logic [23:0] s_axis_tdata;
    logic        m_axis_tvalid, m_axis_tready;
    logic [23:0] m_axis_tdata;

    axis_scoreboard sb;

    axis_deadzone_curve_scaler dut (.*);

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #50ms;
        $display("tb: done, errors");
        $finish;
    end

    // result side: random wait before each transfer, check on each transfer
    initial begin
        int w;
        m_axis_tready = 0;
        forever begin
            w = $urandom_range(0, 1) ? 0 : $urandom_range(0, 16);
            if (w != 0) begin
                m_axis_tready <= 1'b0;
                repeat (w) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!(m_axis_tvalid === 1'b1 && m_axis_tready));
            sb.check_result(m_axis_tdata);
        end
    end

    task automatic write_reg(logic [2:0] idx, logic [6:0] val);
        i_cfg_we <= 1; i_cfg_index <= idx; i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 0;
        case (idx)
            REG_DEAD_ZONE:   sb.dz_pct = val;
            REG_SENSITIVITY: sb.sens = val[3:0];
            REG_AXIS_COUNT:  sb.n_axes = val[2:0];
            REG_TRIGGERS:    sb.trig = val[0];
            REG_ABS_MASK:    sb.abs_mask = val[5:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    // valid stays high into the next transfer when no gap is drawn
    task automatic send_sample(logic [2:0] a, logic [15:0] v, logic rc, bit gaps);
        int w;
        w = gaps ? $urandom_range(0, 16) : 0;
        if (w != 0) begin
            s_axis_tvalid <= 0;
            repeat (w) @(posedge i_clk);
        end
        s_axis_tvalid <= 1;
        s_axis_tdata <= {5'b0, v, a};
        s_axis_tuser <= rc;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_sample(a, v, rc);
    endtask

    task automatic drain();
        int guard;
        guard = 0;
        s_axis_tvalid <= 0;
        while (sb.pos_q.size() != 0 && guard < 200000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (60) @(posedge i_clk);
    endtask

    task automatic setting(logic [6:0] dz, logic [3:0] s, logic [2:0] n, logic t,
                           logic [5:0] m);
        write_reg(REG_DEAD_ZONE, dz);
        write_reg(REG_SENSITIVITY, {3'b0, s});
        write_reg(REG_AXIS_COUNT, {4'b0, n});
        write_reg(REG_TRIGGERS, {6'b0, t});
        write_reg(REG_ABS_MASK, {1'b0, m});
    endtask

    function automatic logic [15:0] pick_value();
        case ($urandom_range(0, 5))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'($urandom_range(0, 15)) - 16'd8;
            default: return 16'($urandom);
        endcase
    endfunction

    initial begin
        bit gaps;
        sb = new();
        i_rst_n = 0; i_cfg_we = 0; i_cfg_index = 0; i_cfg_data = 0;
        s_axis_tvalid = 0; s_axis_tdata = 0; s_axis_tuser = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // reset defaults: no axes present
        send_sample(3'd0, 16'h1234, 1'b0, 0);
        send_sample(3'd7, 16'h7FFF, 1'b1, 0);
        drain();

        setting(7'd10, 4'd9, 3'd6, 1'b0, 6'd4);
        send_sample(3'd0, 16'h7FFF, 1'b0, 0);
        send_sample(3'd0, 16'h8000, 1'b0, 0);
        send_sample(3'd2, 16'h8000, 1'b0, 0);
        send_sample(3'd2, 16'h7FFF, 1'b0, 0);
        send_sample(3'd1, 16'h0100, 1'b0, 0);   // inside dead zone
        send_sample(3'd6, 16'h4000, 1'b0, 0);   // beyond storage
        send_sample(3'd3, 16'h7FFF, 1'b1, 0);   // centre at top end
        send_sample(3'd3, 16'h7000, 1'b0, 0);
        send_sample(3'd3, 16'h8000, 1'b0, 0);
        drain();
        setting(7'd0, 4'd0, 3'd7, 1'b1, 6'd0);   // count above max, triggers
        send_sample(3'd5, 16'h8000, 1'b1, 0);
        send_sample(3'd5, 16'h4000, 1'b0, 0);
        send_sample(3'd4, 16'hC000, 1'b0, 0);
        send_sample(3'd0, 16'h2000, 1'b0, 0);
        drain();
        setting(7'd100, 4'd15, 3'd3, 1'b1, 6'd63);
        send_sample(3'd5, 16'h8000, 1'b0, 0);
        send_sample(3'd1, 16'h8000, 1'b0, 0);
        send_sample(3'd4, 16'h7FFF, 1'b0, 0);
        drain();
        write_reg(REG_ABS_MASK, 7'd0);
        send_sample(3'd1, 16'h7FFF, 1'b0, 0);
        send_sample(3'd0, 16'h8000, 1'b0, 0);
        drain();

        for (int ph = 0; ph < 17; ph++) begin
            case (ph % 4)
                0: setting(7'($urandom_range(0, 30)), 4'($urandom_range(0, 15)),
                           3'($urandom_range(0, 7)), 1'($urandom), 6'($urandom));
                1: setting(7'd100, 4'd0, 3'd6, 1'($urandom), 6'($urandom));
                2: setting(7'd0, 4'd9, 3'd6, 1'b1, 6'd0);
                default: setting(7'($urandom_range(0, 100)), 4'($urandom_range(0, 9)),
                                 3'($urandom_range(1, 6)), 1'($urandom), 6'($urandom));
            endcase
            gaps = ph % 3 != 2;
            for (int k = 0; k < 100; k++)
                send_sample(3'($urandom_range(0, 9) == 0 ? $urandom_range(0, 7)
                                                         : $urandom_range(0, 5)),
                            pick_value(), $urandom_range(0, 9) == 0,
                            gaps && ($urandom_range(0, 1) != 0));
            drain();
        end

        if (sb.errors == 0 && sb.pos_q.size() == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end
endmodule

### filelist.f
src/adcs_pkg.sv
src/adcs_divider.sv
src/axis_deadzone_curve_scaler.sv
src/adcs_checker.sv
tb/tb.sv
